>>> design/ntm_pkg.sv
// ntm_pkg: shared constants and control types for the nearest timestamp matcher
// used by ntm_ctrl, ntm_datapath and nearest_timestamp_matcher; no dependencies

package ntm_pkg;

    // field and register widths
    localparam int STAMP_W = 63;
    localparam int TAG_W   = 16;
    localparam int CFG_W   = 32;

    // default history depth
    localparam int FIFO_DEPTH_DEFAULT = 256;

    // register reset values, in nanoseconds
    localparam logic [CFG_W-1:0] MATCH_THRESHOLD_RESET = 32'd50000000;
    localparam logic [CFG_W-1:0] PRUNE_WINDOW_RESET    = 32'd200000000;

    // register indexes
    localparam logic REG_MATCH_THRESHOLD = 1'b0;
    localparam logic REG_PRUNE_WINDOW    = 1'b1;

    // input command codes
    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_ANCHOR = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic store_wr;      // append the incoming stamp and tag
        logic anchor_start;  // latch anchor, reset scan and accumulators
        logic scan_en;       // issue memory reads while entries remain
        logic finish;        // apply pruning and load the result register
    } ntm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_busy;     // reads outstanding or pipeline not drained
        logic out_free;      // result register can take a new transaction
    } ntm_status_t;

endpackage

>>> design/ntm_ctrl.sv
// ntm_ctrl: sequencing state machine for the nearest timestamp matcher
// depends on ntm_pkg (command and status types, command codes)

module ntm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                command,
    output logic                in_stall,
    input  ntm_pkg::ntm_status_t status,
    output ntm_pkg::ntm_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // next state and command decode
    always_comb
    begin
        state_next       = state_reg;
        cmd.store_wr     = 1'b0;
        cmd.anchor_start = 1'b0;
        cmd.scan_en      = 1'b0;
        cmd.finish       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == ntm_pkg::CMD_ANCHOR)
                    begin
                        cmd.anchor_start = 1'b1;
                        state_next       = ST_SCAN;
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (!status.scan_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // finishing always returns to idle once the result register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && status.out_free) |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");

    // a scan always starts from an accepted anchor transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_IDLE)
            |-> $past(accept && command == ntm_pkg::CMD_ANCHOR))
        else $error("scan entered without an anchor transaction");

endmodule

>>> design/ntm_datapath.sv
// ntm_datapath: stamp/tag ring memory, scan pipeline, prune counter and result register
// depends on ntm_pkg (widths, reset values, register indexes, command and status types)

module ntm_datapath
#(
    parameter int FIFO_DEPTH = ntm_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ntm_pkg::ntm_cmd_t                 cmd,
    output ntm_pkg::ntm_status_t              status,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [ntm_pkg::CFG_W-1:0]         cfg_data,
    input  logic [ntm_pkg::STAMP_W-1:0]       stamp_ns,
    input  logic [ntm_pkg::TAG_W-1:0]         item_tag,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ntm_pkg::TAG_W-1:0]         anchor_tag,
    output logic                              matched,
    output logic [ntm_pkg::TAG_W-1:0]         partner_tag,
    output logic [ntm_pkg::STAMP_W-1:0]       gap_ns
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = ntm_pkg::STAMP_W;
    localparam int TW = ntm_pkg::TAG_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(FIFO_DEPTH);
    localparam logic [CW:0]   DEPTH_SUM = (CW+1)'(FIFO_DEPTH);

    // configuration registers
    logic [ntm_pkg::CFG_W-1:0] threshold_reg;
    logic [ntm_pkg::CFG_W-1:0] prune_window_reg;

    // ring pointers and occupancy
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    // anchor transaction
    logic [SW-1:0] anchor_stamp_reg;
    logic [TW-1:0] anchor_tag_reg;
    logic [SW-1:0] bound_reg;
    logic [SW-1:0] bound_calc;
    logic [SW-1:0] window_ext;

    // read issue
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] issue_cnt_reg;
    logic          issue_done;
    logic          rd_en;

    // memory and pipeline
    logic [SW-1:0] stamp_mem [FIFO_DEPTH];
    logic [TW-1:0] tag_mem   [FIFO_DEPTH];
    logic          v1_reg;
    logic [SW-1:0] rd_stamp_reg;
    logic [TW-1:0] rd_tag_reg;
    logic          v2_reg;
    logic [SW-1:0] gap_reg;
    logic [TW-1:0] tag2_reg;
    logic          old2_reg;
    logic [SW-1:0] gap_calc;

    // running best and prune prefix
    logic          found_reg;
    logic [SW-1:0] best_gap_reg;
    logic [TW-1:0] best_tag_reg;
    logic          in_prefix_reg;
    logic [CW-1:0] prune_cnt_reg;

    // result
    logic          out_valid_reg;
    logic [TW-1:0] anchor_tag_out_reg;
    logic          matched_reg;
    logic [TW-1:0] partner_tag_reg;
    logic [SW-1:0] gap_out_reg;
    logic          hit;
    logic [CW:0]   head_sum;
    logic [CW:0]   head_wrapped;

    assign window_ext = SW'(prune_window_reg);
    assign bound_calc = (stamp_ns >= window_ext) ? (stamp_ns - window_ext) : '0;
    assign issue_done = (issue_cnt_reg == count_reg);
    assign rd_en      = cmd.scan_en && !issue_done;
    assign gap_calc   = (rd_stamp_reg >= anchor_stamp_reg) ?
                        (rd_stamp_reg - anchor_stamp_reg) :
                        (anchor_stamp_reg - rd_stamp_reg);
    assign hit        = found_reg && (best_gap_reg < SW'(threshold_reg));

    assign status.scan_busy = !issue_done || v1_reg || v2_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign anchor_tag  = anchor_tag_out_reg;
    assign matched     = matched_reg;
    assign partner_tag = partner_tag_reg;
    assign gap_ns      = gap_out_reg;

    // front pointer after dropping the pruned prefix
    assign head_sum     = (CW+1)'(head_reg) + (CW+1)'(prune_cnt_reg);
    assign head_wrapped = (head_sum >= DEPTH_SUM) ? (head_sum - DEPTH_SUM) : head_sum;

    // ring pointer and occupancy updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.store_wr)
        begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            if (count_reg == DEPTH_CNT)
            begin
                head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            head_next  = head_wrapped[AW-1:0];
            count_next = count_reg - prune_cnt_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= ntm_pkg::MATCH_THRESHOLD_RESET;
            prune_window_reg <= ntm_pkg::PRUNE_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ntm_pkg::REG_MATCH_THRESHOLD)
            begin
                threshold_reg <= cfg_data;
            end
            else
            begin
                prune_window_reg <= cfg_data;
            end
        end
    end

    // control state: pointers, read issue, pipeline valids, accumulators, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            issue_cnt_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            in_prefix_reg <= 1'b0;
            prune_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;

            if (cmd.anchor_start)
            begin
                rd_ptr_reg    <= head_reg;
                issue_cnt_reg <= '0;
                found_reg     <= 1'b0;
                in_prefix_reg <= 1'b1;
                prune_cnt_reg <= '0;
            end
            else
            begin
                if (rd_en)
                begin
                    rd_ptr_reg    <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (v2_reg)
                begin
                    found_reg <= 1'b1;
                    if (in_prefix_reg && old2_reg)
                    begin
                        prune_cnt_reg <= prune_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        in_prefix_reg <= 1'b0;
                    end
                end
                else if (cmd.finish)
                begin
                    // pruned entries leave the ring here
                    prune_cnt_reg <= '0;
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            stamp_mem[tail_reg] <= stamp_ns;
            tag_mem[tail_reg]   <= item_tag;
        end
        if (rd_en)
        begin
            rd_stamp_reg <= stamp_mem[rd_ptr_reg];
            rd_tag_reg   <= tag_mem[rd_ptr_reg];
        end
    end

    // payload: anchor latch, gap stage, best tracking, result
    always_ff @(posedge clk)
    begin
        if (cmd.anchor_start)
        begin
            anchor_stamp_reg <= stamp_ns;
            anchor_tag_reg   <= item_tag;
            bound_reg        <= bound_calc;
        end
        if (v1_reg)
        begin
            gap_reg  <= gap_calc;
            tag2_reg <= rd_tag_reg;
            old2_reg <= (rd_stamp_reg < bound_reg);
        end
        // strict compare keeps the front-most entry on equal gaps
        if (v2_reg && !cmd.anchor_start && (!found_reg || gap_reg < best_gap_reg))
        begin
            best_gap_reg <= gap_reg;
            best_tag_reg <= tag2_reg;
        end
        if (cmd.finish)
        begin
            anchor_tag_out_reg <= anchor_tag_reg;
            matched_reg        <= hit;
            partner_tag_reg    <= hit ? best_tag_reg : '0;
            gap_out_reg        <= hit ? best_gap_reg : '0;
        end
    end

    // occupancy never exceeds the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond ring size");

    // empty or full ring has front and back pointers together
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == DEPTH_CNT) |-> head_reg == tail_reg)
        else $error("ring pointers inconsistent with occupancy");

    // pruning never drops more entries than are stored
    assert property (@(posedge clk) disable iff (!rst_n)
        prune_cnt_reg <= count_reg)
        else $error("prune count beyond occupancy");

    // reads are only issued for stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> issue_cnt_reg < count_reg)
        else $error("read issued past the stored entries");

endmodule

>>> design/nearest_timestamp_matcher.sv
// nearest_timestamp_matcher: top level, joins the controller and the datapath
// depends on ntm_pkg, ntm_ctrl and ntm_datapath

// Store transactions (command 0) append a stamp and tag to a ring of FIFO_DEPTH entries,
// overwriting the oldest when full, and never leave the block busy. An anchor transaction
// (command 1) reads every stored entry through the single read port of the stamp memory,
// one entry per cycle, keeping the nearest stamp (front-most on ties) and counting the
// front run of entries older than anchor minus prune_window_ns; once the reads have drained
// from the pipeline, the result register is loaded, later if the previous result is still
// held by out_stall. Exactly one result transaction follows each anchor; matched is set
// when the nearest gap is strictly below match_threshold_ns, otherwise partner_tag and
// gap_ns are zero. A store may be accepted while a result waits in the output register.
// No clearing pass is needed after reset.

module nearest_timestamp_matcher
#(
    parameter int FIFO_DEPTH = ntm_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [ntm_pkg::STAMP_W-1:0]   stamp_ns,
    input  logic [ntm_pkg::TAG_W-1:0]     item_tag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ntm_pkg::TAG_W-1:0]     anchor_tag,
    output logic                          matched,
    output logic [ntm_pkg::TAG_W-1:0]     partner_tag,
    output logic [ntm_pkg::STAMP_W-1:0]   gap_ns,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [ntm_pkg::CFG_W-1:0]     cfg_data
);

    ntm_pkg::ntm_cmd_t    cmd;
    ntm_pkg::ntm_status_t status;

    // sequencing
    ntm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // storage, scan and result
    ntm_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stamp_ns    (stamp_ns),
        .item_tag    (item_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .anchor_tag  (anchor_tag),
        .matched     (matched),
        .partner_tag (partner_tag),
        .gap_ns      (gap_ns)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for nearest_timestamp_matcher
// depends on ntm_pkg and nearest_timestamp_matcher; predicts each anchor result itself unless the script types it in

module tb;

    localparam int STAMP_W = ntm_pkg::STAMP_W;
    localparam int TAG_W = ntm_pkg::TAG_W;
    localparam int CFG_W = ntm_pkg::CFG_W;
    localparam int DEPTH = ntm_pkg::FIFO_DEPTH_DEFAULT;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int PRED_DEPTH = 16;
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // one anchor result as it leaves the block
    typedef struct packed {
        logic [TAG_W-1:0]   anchor;
        logic               hit;
        logic [TAG_W-1:0]   partner;
        logic [STAMP_W-1:0] gap;
    } pairing_t;

    // one directed transaction, with the result typed in where it is obvious
    typedef struct packed {
        logic               cmd;
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
        bit                 known;
        logic               hit;
        logic [TAG_W-1:0]   partner;
        logic [STAMP_W-1:0] gap;
    } step_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [STAMP_W-1:0]  stamp_ns;
    logic [TAG_W-1:0]    item_tag;
    logic                out_valid;
    logic                out_stall;
    logic [TAG_W-1:0]    anchor_tag;
    logic                matched;
    logic [TAG_W-1:0]    partner_tag;
    logic [STAMP_W-1:0]  gap_ns;
    logic                cfg_write;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    // predictor state: history ring and register copies
    logic [STAMP_W-1:0]  ring_stamp [DEPTH];
    logic [TAG_W-1:0]    ring_tag [DEPTH];
    logic [SLOT_W-1:0]   head_slot;
    int                  fill_level;
    logic [CFG_W-1:0]    match_limit;
    logic [CFG_W-1:0]    prune_span;

    // predicted results in order, written and read through running counts
    pairing_t            predicted [PRED_DEPTH];
    int                  pred_wr = 0;
    int                  pred_rd = 0;
    int                  err_count;
    int                  stall_pct;
    int                  stall_left;
    step_row_t           script [13];

    nearest_timestamp_matcher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .stamp_ns    (stamp_ns),
        .item_tag    (item_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .anchor_tag  (anchor_tag),
        .matched     (matched),
        .partner_tag (partner_tag),
        .gap_ns      (gap_ns),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("nearest_timestamp_matcher test failed");
        $finish;
    end

    // apply one accepted transaction to the predicted history
    function automatic void align_event(input logic cmd, input logic [STAMP_W-1:0] stamp,
                                        input logic [TAG_W-1:0] tag, output bit produced,
                                        output pairing_t res);
        logic [STAMP_W-1:0] best_gap;
        logic [STAMP_W-1:0] gap;
        logic [STAMP_W-1:0] bound;
        logic [STAMP_W-1:0] s;
        logic [TAG_W-1:0]   best_tag;
        logic [SLOT_W-1:0]  slot;
        bit                 found;
        int                 k;
        produced = 1'b0;
        res = '0;
        // store: drop the oldest when full, then append
        if (cmd == ntm_pkg::CMD_STORE)
        begin
            if (fill_level == DEPTH)
            begin
                head_slot = head_slot + 1'b1;
                fill_level--;
            end
            slot = head_slot + SLOT_W'(fill_level);
            ring_stamp[slot] = stamp;
            ring_tag[slot] = tag;
            fill_level++;
            return;
        end
        // anchor: nearest stamp, front-most entry wins ties
        found = 1'b0;
        best_gap = '0;
        best_tag = '0;
        for (k = 0; k < fill_level; k++)
        begin
            slot = head_slot + SLOT_W'(k);
            s = ring_stamp[slot];
            gap = (s >= stamp) ? s - stamp : stamp - s;
            if (!found || gap < best_gap)
            begin
                found = 1'b1;
                best_gap = gap;
                best_tag = ring_tag[slot];
            end
        end
        // prune the front run, bound saturating at zero
        bound = (stamp >= STAMP_W'(prune_span)) ? stamp - STAMP_W'(prune_span) : '0;
        while (fill_level > 0 && ring_stamp[head_slot] < bound)
        begin
            head_slot = head_slot + 1'b1;
            fill_level--;
        end
        res.anchor = tag;
        res.hit = found && (best_gap < STAMP_W'(match_limit));
        res.partner = res.hit ? best_tag : '0;
        res.gap = res.hit ? best_gap : '0;
        produced = 1'b1;
    endfunction

    // drive one input transaction and wait for it to be taken
    task automatic send(input logic cmd, input logic [STAMP_W-1:0] stamp,
                        input logic [TAG_W-1:0] tag, input bit known, input pairing_t fixed);
        pairing_t guess;
        bit       produced;
        @(negedge clk);
        in_valid <= 1'b1;
        command <= cmd;
        stamp_ns <= stamp;
        item_tag <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        align_event(cmd, stamp, tag, produced, guess);
        if (produced)
        begin
            predicted[pred_wr % PRED_DEPTH] = known ? fixed : guess;
            pred_wr++;
        end
    endtask

    // sender gap: hold in_valid low, length set by n
    task automatic hold_off(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // stop sending until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pred_wr != pred_rd)
            @(posedge clk);
    endtask

    // idle block: results drained, then a wait for store transactions in flight
    task automatic settle();
        drain();
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == ntm_pkg::REG_MATCH_THRESHOLD)
            match_limit = value;
        else
            prune_span = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // one random phase: new register settings, then a sensor-like stream with some noise
    task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] window,
                             input logic [STAMP_W-1:0] start, input int store_pct,
                             input int noise_pct, input logic [31:0] step_max,
                             input int count, input int busy_pct);
        logic [STAMP_W-1:0] clock_ns;
        logic [STAMP_W-1:0] stamp;
        logic [31:0]        jitter;
        logic               cmd;
        int                 i;
        settle();
        write_reg(ntm_pkg::REG_MATCH_THRESHOLD, thr);
        write_reg(ntm_pkg::REG_PRUNE_WINDOW, window);
        stall_pct = busy_pct / 2;
        clock_ns = start;
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            else if ($urandom_range(0, 99) < busy_pct)
                hold_off($urandom_range(1, 11));
            cmd = ($urandom_range(0, 99) < store_pct) ? ntm_pkg::CMD_STORE
                                                      : ntm_pkg::CMD_ANCHOR;
            if ($urandom_range(0, 99) < noise_pct)
                stamp = STAMP_W'({$urandom, $urandom});
            else
            begin
                clock_ns = clock_ns + $urandom_range(0, step_max);
                jitter = $urandom_range(0, step_max);
                // anchors land near the stored stamps, offset by a random jitter that may be zero
                if (cmd == ntm_pkg::CMD_STORE)
                    stamp = clock_ns;
                else if (clock_ns > jitter)
                    stamp = clock_ns - jitter;
                else
                    stamp = clock_ns + jitter;
            end
            send(cmd, stamp, TAG_W'($urandom), 1'b0, '0);
        end
    endtask

    // receiver stalls in random bursts
    initial
    begin
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_pct == 0)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // compare every result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        pairing_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pred_wr == pred_rd)
            begin
                $error("result with none pending: anchor_tag %h", anchor_tag);
                err_count++;
            end
            else
            begin
                want = predicted[pred_rd % PRED_DEPTH];
                pred_rd++;
                if (anchor_tag !== want.anchor)
                begin
                    $error("anchor_tag expected %h actual %h", want.anchor, anchor_tag);
                    err_count++;
                end
                if (matched !== want.hit)
                begin
                    $error("matched expected %b actual %b", want.hit, matched);
                    err_count++;
                end
                if (partner_tag !== want.partner)
                begin
                    $error("partner_tag expected %h actual %h", want.partner, partner_tag);
                    err_count++;
                end
                if (gap_ns !== want.gap)
                begin
                    $error("gap_ns expected %0d actual %0d", want.gap, gap_ns);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        pairing_t fixed;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = ntm_pkg::CMD_STORE;
        stamp_ns = '0;
        item_tag = '0;
        cfg_write = 1'b0;
        cfg_index = ntm_pkg::REG_MATCH_THRESHOLD;
        cfg_data = '0;
        err_count = 0;
        stall_pct = 10;
        head_slot = '0;
        fill_level = 0;
        match_limit = ntm_pkg::MATCH_THRESHOLD_RESET;
        prune_span = ntm_pkg::PRUNE_WINDOW_RESET;

        // reset register values: threshold 50 ms, prune window 200 ms
        script = '{
            // empty history, both stamp extremes
            '{ntm_pkg::CMD_ANCHOR, 63'd0, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, STAMP_MAX, 16'h0000, 1'b1, 1'b0, 16'h0000, 63'd0},
            // exact hit, prune bound saturates
            '{ntm_pkg::CMD_STORE, 63'd1000, 16'h0001, 1'b0, 1'b0, 16'h0000, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, 63'd1000, 16'h00A0, 1'b1, 1'b1, 16'h0001, 63'd0},
            // equal gaps, front-most entry wins
            '{ntm_pkg::CMD_STORE, 63'd3000, 16'h0002, 1'b0, 1'b0, 16'h0000, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, 63'd2000, 16'h00A1, 1'b1, 1'b1, 16'h0001, 63'd1000},
            // just inside, then exactly on the threshold
            '{ntm_pkg::CMD_ANCHOR, 63'd50_001_000, 16'h00A2, 1'b0, 1'b0, 16'h0000, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, 63'd50_003_000, 16'h00A3, 1'b1, 1'b0, 16'h0000, 63'd0},
            // largest stamp prunes the old entries
            '{ntm_pkg::CMD_STORE, STAMP_MAX, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, STAMP_MAX, 16'h5555, 1'b1, 1'b1, 16'hFFFF, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, 63'd0, 16'hAAAA, 1'b1, 1'b0, 16'h0000, 63'd0},
            // zero stamp and tag
            '{ntm_pkg::CMD_STORE, 63'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 63'd0},
            '{ntm_pkg::CMD_ANCHOR, 63'd100, 16'h1234, 1'b0, 1'b0, 16'h0000, 63'd0}
        };

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed transactions
        foreach (script[r])
        begin
            if ($urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 11));
            fixed.anchor = script[r].tag;
            fixed.hit = script[r].hit;
            fixed.partner = script[r].partner;
            fixed.gap = script[r].gap;
            send(script[r].cmd, script[r].stamp, script[r].tag, script[r].known, fixed);
        end

        // widest settings, mostly stores: history fills and overflows
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, STAMP_W'({$urandom, $urandom}),
                  90, 0, 32'd1_000_000, 320, 25);
        // zero settings: never a match, the front run of entries older than the anchor goes
        run_phase(32'h0000_0000, 32'h0000_0000, '0, 50, 10, 32'd1000, 50, 25);
        // arbitrary settings
        run_phase($urandom, $urandom, STAMP_W'({$urandom, $urandom}), 60, 10,
                  $urandom_range(1, 50_000_000), 60, 40);
        // tiny steps and windows: ties and saturated prune bounds
        run_phase($urandom_range(0, 8), $urandom_range(0, 40), '0, 65, 5, 32'd6, 50, 20);
        // reset values again, no random sender gaps or receiver stalls
        run_phase(ntm_pkg::MATCH_THRESHOLD_RESET, ntm_pkg::PRUNE_WINDOW_RESET,
                  STAMP_W'({$urandom, $urandom}), 70, 5, 32'd20_000_000, 50, 0);

        drain();
        repeat (300)
            @(posedge clk);
        if (err_count == 0)
            $display("nearest_timestamp_matcher test passed");
        else
            $display("nearest_timestamp_matcher test failed");
        $finish;
    end

endmodule

>>> sim.f
design/ntm_pkg.sv
design/ntm_ctrl.sv
design/ntm_datapath.sv
design/nearest_timestamp_matcher.sv
tb/tb.sv
